// ===== design/orl_pkg.sv =====
// Package for the overwriting ring log: request and status codes, default sizes.
// Used by overwriting_ring_log; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package orl_pkg;

   localparam int DEPTH_DEFAULT       = 256;
   localparam int ENTRY_WIDTH_DEFAULT = 64;

   localparam int REQ_KIND_W    = 3;
   localparam int STATUS_W      = 2;
   localparam int ENTRY_PORT_W  = 64;
   localparam int POSITION_W    = 16;
   localparam int DROP_W        = 16;
   localparam int REQ_TDATA_W   = 96;

   typedef enum logic [REQ_KIND_W-1:0] {
      REQ_PUSH  = 3'd0,
      REQ_POP   = 3'd1,
      REQ_PEEK  = 3'd2,
      REQ_DROP  = 3'd3,
      REQ_FLUSH = 3'd4,
      REQ_COUNT = 3'd5
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

endpackage

`default_nettype wire

// ===== design/overwriting_ring_log.sv =====
// Overwriting ring log: the top level, with entry memory, pointers and result register.
// Depends on orl_pkg for request codes, status codes and default sizes.
//
// Requests arrive on the req_ channel, one transaction each; req_tuser carries the
// request kind (push, pop, peek, drop, flush, count) and req_tdata the entry, the
// peek offset and the drop count. Every request produces exactly one transaction
// on the rsp_ channel with a status in rsp_tuser and the entry read plus the fill
// count after the request in rsp_tdata. Pushing into a full log overwrites the
// oldest entry. The result appears in the cycle after the request is taken, since
// the entry memory has a registered read port. While results are taken, one request
// per cycle is sustained: pointers and the fill count are updated in the cycle a
// request is taken, and the single memory port pair serves any write or read it needs.
// When the receiver stalls, the pending result holds in its register and a new
// request is taken only in a cycle in which that result leaves. Reset empties the
// log and drops any pending result; the memory contents are not cleared because
// only entries that have been written are ever read.
`timescale 1ns / 1ps
`default_nettype none

module overwriting_ring_log #(
   parameter int DEPTH       = orl_pkg::DEPTH_DEFAULT,
   parameter int ENTRY_WIDTH = orl_pkg::ENTRY_WIDTH_DEFAULT,
   localparam int CW          = $clog2(DEPTH + 1),
   localparam int RSP_TDATA_W = ((orl_pkg::ENTRY_PORT_W + CW + 7) / 8) * 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // Bits from the lowest up: entry_data (64), position (16), drop_count (16).
   input  wire logic [orl_pkg::REQ_TDATA_W-1:0] req_tdata,
   // Bits from the lowest up: req_type (3).
   input  wire logic [orl_pkg::REQ_KIND_W-1:0]  req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // Bits from the lowest up: entry_out (64), entries_held (CW), zero padding.
   output logic [RSP_TDATA_W-1:0]              rsp_tdata,
   // Bits from the lowest up: status (2).
   output logic [orl_pkg::STATUS_W-1:0]        rsp_tuser
);

   localparam int AW    = $clog2(DEPTH);
   localparam int SUM_W = CW + 1;
   localparam int CMP_W = (CW > orl_pkg::POSITION_W) ? CW : orl_pkg::POSITION_W;

   logic [ENTRY_WIDTH-1:0] entry_store [DEPTH];

   logic [AW-1:0]          head_ff, head_in;
   logic [AW-1:0]          tail_ff, tail_in;
   logic [CW-1:0]          fill_ff, fill_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   orl_pkg::status_type    status_ff, status_in;
   logic                   hit_ff, hit_in;
   logic [ENTRY_WIDTH-1:0] rd_data_ff;

   logic                          accept;
   orl_pkg::req_kind_type         kind;
   logic [ENTRY_WIDTH-1:0]        entry_data;
   logic [orl_pkg::POSITION_W-1:0] position;
   logic [orl_pkg::DROP_W-1:0]    drop_count;
   logic                          wr_en, rd_en;
   logic [AW-1:0]                 wr_addr, rd_addr;
   logic [AW-1:0]                 head_next, tail_next, peek_addr, drop_head;
   logic [orl_pkg::ENTRY_PORT_W-1:0] entry_out;

   function automatic logic [AW-1:0] wrap_idx(input logic [SUM_W-1:0] sum);
      logic [SUM_W-1:0] lim;
      lim = SUM_W'(DEPTH);
      if (sum >= lim) begin
         wrap_idx = AW'(sum - lim);
      end else begin
         wrap_idx = AW'(sum);
      end
   endfunction

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign kind       = orl_pkg::req_kind_type'(req_tuser);
   assign entry_data = ENTRY_WIDTH'(req_tdata[orl_pkg::ENTRY_PORT_W-1:0]);
   assign position   = req_tdata[orl_pkg::ENTRY_PORT_W +: orl_pkg::POSITION_W];
   assign drop_count =
      req_tdata[orl_pkg::ENTRY_PORT_W + orl_pkg::POSITION_W +: orl_pkg::DROP_W];

   assign head_next = wrap_idx(SUM_W'(head_ff) + SUM_W'(1));
   assign tail_next = wrap_idx(SUM_W'(tail_ff) + SUM_W'(1));
   assign peek_addr = wrap_idx(SUM_W'(head_ff) + SUM_W'(position));
   assign drop_head = wrap_idx(SUM_W'(head_ff) + SUM_W'(drop_count));

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      fill_in   = fill_ff;
      status_in = orl_pkg::ST_OK;
      hit_in    = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      wr_addr   = tail_ff;
      rd_addr   = head_ff;
      case (kind)
         orl_pkg::REQ_PUSH: begin
            wr_en = 1'b1;
            if (fill_ff == '0) begin
               wr_addr = '0;
               head_in = '0;
               tail_in = AW'(1);
               fill_in = CW'(1);
            end else begin
               tail_in = tail_next;
               if (fill_ff < CW'(DEPTH)) begin
                  fill_in = fill_ff + CW'(1);
               end else begin
                  head_in = head_next;
               end
            end
         end
         orl_pkg::REQ_POP: begin
            if (fill_ff == '0) begin
               status_in = orl_pkg::ST_EMPTY;
            end else begin
               rd_en   = 1'b1;
               hit_in  = 1'b1;
               head_in = head_next;
               fill_in = fill_ff - CW'(1);
            end
         end
         orl_pkg::REQ_PEEK: begin
            rd_addr = peek_addr;
            if (fill_ff == '0) begin
               status_in = orl_pkg::ST_EMPTY;
            end else if (CMP_W'(position) >= CMP_W'(fill_ff)) begin
               status_in = orl_pkg::ST_RANGE;
            end else begin
               rd_en  = 1'b1;
               hit_in = 1'b1;
            end
         end
         orl_pkg::REQ_DROP: begin
            if (fill_ff == '0) begin
               status_in = orl_pkg::ST_EMPTY;
            end else if (CMP_W'(drop_count) > CMP_W'(fill_ff)) begin
               status_in = orl_pkg::ST_RANGE;
            end else begin
               head_in = drop_head;
               fill_in = fill_ff - CW'(drop_count);
            end
         end
         orl_pkg::REQ_FLUSH: begin
            head_in = '0;
            tail_in = '0;
            fill_in = '0;
         end
         orl_pkg::REQ_COUNT: begin
         end
         default: begin
            status_in = orl_pkg::ST_RANGE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            head_ff <= head_in;
            tail_ff <= tail_in;
            fill_ff <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         hit_ff    <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && wr_en) begin
         entry_store[wr_addr] <= entry_data;
      end
      if (accept && rd_en) begin
         rd_data_ff <= entry_store[rd_addr];
      end
   end

   assign entry_out  = hit_ff ? orl_pkg::ENTRY_PORT_W'(rd_data_ff) : '0;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = RSP_TDATA_W'({fill_ff, entry_out});

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for overwriting_ring_log: directed requests from a table, then
// random request bursts, each result checked against the table or a predictor of the ring log.
// Depends on orl_pkg and overwriting_ring_log.
`timescale 1ns / 1ps

module testbench;

   localparam int HELD_W     = $clog2(orl_pkg::DEPTH_DEFAULT + 1);
   localparam int RSP_W      = ((orl_pkg::ENTRY_PORT_W + HELD_W + 7) / 8) * 8;
   localparam int ITEM_COUNT = 1850;
   localparam int IDLE_PCT   = 34;
   localparam int MAX_REPORTS = 10;

   localparam logic [orl_pkg::REQ_KIND_W-1:0] REQ_UNUSED_A = 3'd6;
   localparam logic [orl_pkg::REQ_KIND_W-1:0] REQ_UNUSED_B = 3'd7;

   localparam int MODE_FILL  = 0;
   localparam int MODE_MIXED = 1;
   localparam int MODE_DRAIN = 2;

   typedef struct {
      orl_pkg::status_type               status;
      logic [orl_pkg::ENTRY_PORT_W-1:0]  entry;
      logic [HELD_W-1:0]                 held;
   } log_result_type;

   typedef struct {
      logic [orl_pkg::REQ_KIND_W-1:0]    kind;
      logic [orl_pkg::ENTRY_PORT_W-1:0]  data;
      logic [orl_pkg::POSITION_W-1:0]    pos;
      logic [orl_pkg::DROP_W-1:0]        ndrop;
      bit                                typed;
      orl_pkg::status_type               status;
      logic [orl_pkg::ENTRY_PORT_W-1:0]  entry;
      logic [HELD_W-1:0]                 held;
   } stim_row_type;

   localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   // Rows with typed = 0 are checked against the predictor instead.
   stim_row_type directed_rows[24] = '{
      '{orl_pkg::REQ_COUNT, 64'h0, 16'h0, 16'h0, 1, orl_pkg::ST_OK, 64'h0, 9'd0},
      '{orl_pkg::REQ_POP, 64'h0, 16'h0, 16'h0, 1, orl_pkg::ST_EMPTY, 64'h0, 9'd0},
      '{orl_pkg::REQ_PEEK, 64'h0, 16'h0, 16'h0, 1, orl_pkg::ST_EMPTY, 64'h0, 9'd0},
      '{orl_pkg::REQ_DROP, 64'h0, 16'h0, 16'hFFFF, 1, orl_pkg::ST_EMPTY, 64'h0, 9'd0},
      '{orl_pkg::REQ_PUSH, ONES, 16'h0, 16'h0, 1, orl_pkg::ST_OK, 64'h0, 9'd1},
      '{orl_pkg::REQ_PEEK, 64'h0, 16'h0, 16'h0, 1, orl_pkg::ST_OK, ONES, 9'd1},
      '{orl_pkg::REQ_PEEK, 64'h0, 16'h1, 16'h0, 1, orl_pkg::ST_RANGE, 64'h0, 9'd1},
      '{orl_pkg::REQ_PEEK, 64'h0, 16'hFFFF, 16'h0, 1, orl_pkg::ST_RANGE, 64'h0, 9'd1},
      '{orl_pkg::REQ_PUSH, 64'h0, 16'h0, 16'h0, 1, orl_pkg::ST_OK, 64'h0, 9'd2},
      '{orl_pkg::REQ_DROP, 64'h0, 16'h0, 16'h3, 1, orl_pkg::ST_RANGE, 64'h0, 9'd2},
      '{orl_pkg::REQ_DROP, 64'h0, 16'h0, 16'hFFFF, 1, orl_pkg::ST_RANGE, 64'h0, 9'd2},
      '{orl_pkg::REQ_DROP, 64'h0, 16'h0, 16'h0, 1, orl_pkg::ST_OK, 64'h0, 9'd2},
      '{orl_pkg::REQ_PEEK, 64'h0, 16'h1, 16'h0, 1, orl_pkg::ST_OK, 64'h0, 9'd2},
      '{orl_pkg::REQ_POP, 64'h0, 16'h0, 16'h0, 1, orl_pkg::ST_OK, ONES, 9'd1},
      '{orl_pkg::REQ_POP, 64'h0, 16'h0, 16'h0, 1, orl_pkg::ST_OK, 64'h0, 9'd0},
      '{REQ_UNUSED_A, 64'h0, 16'h0, 16'h0, 1, orl_pkg::ST_RANGE, 64'h0, 9'd0},
      '{REQ_UNUSED_B, ONES, 16'hFFFF, 16'hFFFF, 1, orl_pkg::ST_RANGE, 64'h0, 9'd0},
      '{orl_pkg::REQ_PUSH, 64'h0123_4567_89AB_CDEF, 16'h0, 16'h0, 0, orl_pkg::ST_OK,
        64'h0, 9'd0},
      '{orl_pkg::REQ_PUSH, 64'hFEDC_BA98_7654_3210, 16'h0, 16'h0, 0, orl_pkg::ST_OK,
        64'h0, 9'd0},
      '{orl_pkg::REQ_PEEK, 64'h0, 16'h1, 16'h0, 0, orl_pkg::ST_OK, 64'h0, 9'd0},
      '{orl_pkg::REQ_FLUSH, 64'h0, 16'h0, 16'h0, 1, orl_pkg::ST_OK, 64'h0, 9'd0},
      '{orl_pkg::REQ_PUSH, 64'h8000_0000_0000_0001, 16'h0, 16'h0, 1, orl_pkg::ST_OK,
        64'h0, 9'd1},
      '{orl_pkg::REQ_DROP, 64'h0, 16'h0, 16'h1, 1, orl_pkg::ST_OK, 64'h0, 9'd0},
      '{orl_pkg::REQ_COUNT, 64'h0, 16'h0, 16'h0, 1, orl_pkg::ST_OK, 64'h0, 9'd0}
   };

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [orl_pkg::REQ_TDATA_W-1:0]   req_tdata = '0;
   logic [orl_pkg::REQ_KIND_W-1:0]    req_tuser = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [RSP_W-1:0]                  rsp_tdata;
   logic [orl_pkg::STATUS_W-1:0]      rsp_tuser;

   logic [orl_pkg::ENTRY_PORT_W-1:0]  log_mem [orl_pkg::DEPTH_DEFAULT];
   logic [7:0]                        log_head = '0;
   logic [7:0]                        log_tail = '0;
   logic [HELD_W-1:0]                 log_fill = '0;

   log_result_type           pending_results[$];
   bit                       row_typed = 1'b0;
   log_result_type           row_expect;
   bit                       steady = 1'b0;
   int                       mismatch_count = 0;

   overwriting_ring_log i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Advances the log state by one request and returns the result it should give.
   function automatic log_result_type apply_request(
         logic [orl_pkg::REQ_KIND_W-1:0] kind,
         logic [orl_pkg::ENTRY_PORT_W-1:0] data,
         logic [orl_pkg::POSITION_W-1:0] pos,
         logic [orl_pkg::DROP_W-1:0] ndrop);
      log_result_type res;
      res.status = orl_pkg::ST_OK;
      res.entry  = '0;
      case (kind)
         orl_pkg::REQ_PUSH: begin
            if (log_fill == 0) begin
               log_head = '0;
               log_tail = '0;
            end
            log_mem[log_tail] = data;
            log_tail = log_tail + 8'd1;
            if (log_fill < orl_pkg::DEPTH_DEFAULT) begin
               log_fill = log_fill + 1'b1;
            end else begin
               log_head = log_head + 8'd1;
            end
         end
         orl_pkg::REQ_POP: begin
            if (log_fill == 0) begin
               res.status = orl_pkg::ST_EMPTY;
            end else begin
               res.entry = log_mem[log_head];
               log_head = log_head + 8'd1;
               log_fill = log_fill - 1'b1;
            end
         end
         orl_pkg::REQ_PEEK: begin
            if (log_fill == 0) begin
               res.status = orl_pkg::ST_EMPTY;
            end else if (pos >= log_fill) begin
               res.status = orl_pkg::ST_RANGE;
            end else begin
               res.entry = log_mem[8'(log_head + pos)];
            end
         end
         orl_pkg::REQ_DROP: begin
            if (log_fill == 0) begin
               res.status = orl_pkg::ST_EMPTY;
            end else if (ndrop > log_fill) begin
               res.status = orl_pkg::ST_RANGE;
            end else begin
               log_head = 8'(log_head + ndrop);
               log_fill = log_fill - HELD_W'(ndrop);
            end
         end
         orl_pkg::REQ_FLUSH: begin
            log_head = '0;
            log_tail = '0;
            log_fill = '0;
         end
         orl_pkg::REQ_COUNT: begin
         end
         default: begin
            res.status = orl_pkg::ST_RANGE;
         end
      endcase
      res.held = log_fill;
      return res;
   endfunction

   function automatic logic [orl_pkg::REQ_KIND_W-1:0] pick_kind(int mode);
      int push_pct;
      int r;
      push_pct = (mode == MODE_FILL) ? 85 : (mode == MODE_MIXED) ? 45 : 20;
      if ($urandom_range(0, 99) < push_pct) begin
         return orl_pkg::REQ_PUSH;
      end
      r = $urandom_range(0, 99);
      if (r < 30) return orl_pkg::REQ_POP;
      if (r < 55) return orl_pkg::REQ_PEEK;
      if (r < 75) return orl_pkg::REQ_DROP;
      if (r < 88) return orl_pkg::REQ_COUNT;
      if (r < 93) return (mode == MODE_FILL) ? orl_pkg::REQ_COUNT : orl_pkg::REQ_FLUSH;
      if (r < 97) return REQ_UNUSED_A;
      return REQ_UNUSED_B;
   endfunction

   function automatic logic [orl_pkg::POSITION_W-1:0] pick_position();
      int r;
      r = $urandom_range(0, 99);
      if (log_fill != 0 && r < 70) begin
         return orl_pkg::POSITION_W'($urandom_range(0, int'(log_fill) - 1));
      end
      if (r < 80) return orl_pkg::POSITION_W'(log_fill);
      return orl_pkg::POSITION_W'($urandom);
   endfunction

   function automatic logic [orl_pkg::DROP_W-1:0] pick_drop(int mode);
      int r;
      int small_top;
      r = $urandom_range(0, 99);
      small_top = (log_fill < 4) ? int'(log_fill) : 4;
      if (r < 55 || (mode == MODE_FILL && r < 90)) begin
         return orl_pkg::DROP_W'($urandom_range(0, small_top));
      end
      if (r < 70) return orl_pkg::DROP_W'($urandom_range(0, int'(log_fill)));
      if (r < 80) return orl_pkg::DROP_W'(log_fill + $urandom_range(0, 1));
      return orl_pkg::DROP_W'($urandom);
   endfunction

   // Called and returning at a falling edge; the transaction is taken at a rising edge.
   task automatic drive_request(logic [orl_pkg::REQ_KIND_W-1:0] kind,
                                logic [orl_pkg::ENTRY_PORT_W-1:0] data,
                                logic [orl_pkg::POSITION_W-1:0] pos,
                                logic [orl_pkg::DROP_W-1:0] ndrop,
                                bit typed, log_result_type typed_res);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {ndrop, pos, data};
      row_typed  <= typed;
      row_expect <= typed_res;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin : track_log
      log_result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            want = apply_request(req_tuser, req_tdata[63:0], req_tdata[79:64], req_tdata[95:80]);
            if (row_typed) want = row_expect;
            pending_results.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: unexpected result status %0d entry %h held %0d", $realtime,
                           rsp_tuser, rsp_tdata[63:0], rsp_tdata[64 +: HELD_W]);
               end
            end else begin
               want = pending_results.pop_front();
               if (rsp_tuser !== want.status || rsp_tdata[63:0] !== want.entry ||
                   rsp_tdata[64 +: HELD_W] !== want.held) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("%0t: result mismatch: expected status %0d entry %h held %0d,",
                              $realtime, want.status, want.entry, want.held);
                     $display("   got status %0d entry %h held %0d",
                              rsp_tuser, rsp_tdata[63:0], rsp_tdata[64 +: HELD_W]);
                  end
               end
            end
         end
      end
   end

   initial begin : stimulus
      log_result_type typed_res;
      log_result_type unused_res;
      int mode;
      unused_res = '{orl_pkg::ST_OK, '0, '0};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         typed_res = '{directed_rows[i].status, directed_rows[i].entry, directed_rows[i].held};
         drive_request(directed_rows[i].kind, directed_rows[i].data, directed_rows[i].pos,
                       directed_rows[i].ndrop, directed_rows[i].typed, typed_res);
      end

      // The opening burst fills the log well past full so that overwriting is exercised.
      mode = MODE_FILL;
      for (int n = 0; n < ITEM_COUNT; n++) begin
         if (n >= 400 && n % 150 == 0) mode = $urandom_range(MODE_FILL, MODE_DRAIN);
         steady <= (n >= 900 && n < 1200);
         drive_request(pick_kind(mode), {$urandom, $urandom}, pick_position(), pick_drop(mode),
                       1'b0, unused_res);
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
